[rtl/flp_pkg.sv]
package flp_pkg;

    localparam int TAPS       = 17;
    localparam int HIST       = TAPS - 1;
    localparam int OUT_SHIFT  = 16;
    localparam int COEF_COUNT = 9;

    localparam int SAMPLE_W   = 32;
    localparam int TIME_W     = 32;
    localparam int COEF_W     = 32;
    localparam int ACC_W      = 64;
    localparam int RES_W      = 48;

    localparam int IN_W       = SAMPLE_W + TIME_W + SAMPLE_W;
    localparam int OUT_W      = RES_W + TIME_W + SAMPLE_W;

    localparam int TAP_IDX_W  = $clog2(TAPS);
    localparam int HIST_IDX_W = $clog2(HIST);
    localparam int FILL_W     = $clog2(HIST + 1);
    localparam int COEF_IDX_W = $clog2(COEF_COUNT);

    localparam logic signed [COEF_W-1:0] HALF_TAPS [COEF_COUNT] = '{
        -32'sd281468814, 32'sd106520334, 32'sd127255214,
         32'sd162830244, 32'sd205727178, 32'sd248615023,
         32'sd284705529, 32'sd308612275, 32'sd316959956
    };

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    // Symmetric tap lookup, clamped to the center coefficient.
    function automatic logic signed [COEF_W-1:0] tap_at(input logic [TAP_IDX_W-1:0] i);
        int m;
        int k;
        m = TAPS - 1 - int'(i);
        k = (int'(i) < m) ? int'(i) : m;
        if (k < 0)
            k = 0;
        if (k > COEF_COUNT - 1)
            k = COEF_COUNT - 1;
        return HALF_TAPS[k[COEF_IDX_W-1:0]];
    endfunction

endpackage

[rtl/flp_delay.sv]
module flp_delay
    import flp_pkg::*;
(
    input  logic                       clk,
    input  logic                       push_en,
    input  logic signed [SAMPLE_W-1:0] push_data,
    input  logic [HIST_IDX_W-1:0]      rd_idx,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] delay_reg [HIST];

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            for (int i = 0; i < HIST - 1; i++)
            begin
                delay_reg[i] <= delay_reg[i + 1];
            end
            delay_reg[HIST - 1] <= push_data;
        end
    end

    assign rd_data = delay_reg[rd_idx];

endmodule

[rtl/flp_mac.sv]
module flp_mac
    import flp_pkg::*;
(
    input  logic                       clk,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] operand,
    input  logic signed [COEF_W-1:0]   coef,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= ACC_W'(operand) * ACC_W'(coef);
        if (ctrl.clear)
            acc_reg <= '0;
        else if (ctrl.acc_en)
            acc_reg <= acc_reg + prod_reg;
    end

    assign acc = acc_reg;

endmodule

[rtl/fir_lowpass_17tap.sv]
// Channel   Direction  Transfer when         Payload
// s_*       in         s_tvalid & s_tready   sample_magnitude, sample_time, raw_magnitude
// m_*       out        m_tvalid & m_tready   filtered_magnitude, out_time, out_raw_magnitude
//
// The first 16 samples after reset fill the delay line and give no result.
// After that each sample is accepted, then passes 17 times through the shared multiplier,
// gets one final accumulate and loads the output register; no new sample is taken meanwhile.
// Reset is asynchronous and active low; it clears the sequencer, fill count and output valid.
// A stalled output holds the block in its final state until the waiting result is taken.
module fir_lowpass_17tap
    import flp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // sample_magnitude [31:0], sample_time [63:32], raw_magnitude [95:64]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // filtered_magnitude [47:0], out_time [79:48], out_raw_magnitude [111:80]
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [TAP_IDX_W-1:0]       cnt_reg, cnt_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic                       m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]           m_data_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]          time_reg;
    logic [SAMPLE_W-1:0]        raw_reg;

    logic                       accept;
    logic                       warm;
    logic                       out_load;
    logic                       push_en;
    logic signed [SAMPLE_W-1:0] push_data;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic signed [SAMPLE_W-1:0] operand;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_shifted;
    mac_ctrl_t                  ctrl;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign warm     = (fill_reg < FILL_W'(HIST));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        out_load    = 1'b0;
        push_en     = 1'b0;
        push_data   = sample_reg;
        ctrl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (warm)
                    begin
                        push_en   = 1'b1;
                        push_data = s_tdata[SAMPLE_W-1:0];
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        ctrl.clear = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_en = (cnt_reg != '0);
                if (cnt_reg == TAP_IDX_W'(TAPS - 1))
                    state_next = ST_ADD;
                else
                    cnt_next = cnt_reg + TAP_IDX_W'(1);
            end
            ST_ADD:
            begin
                ctrl.acc_en = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    push_en    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !warm)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            time_reg   <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
            raw_reg    <= s_tdata[IN_W-1:SAMPLE_W+TIME_W];
        end
        if (out_load)
            m_data_reg <= {raw_reg, time_reg, acc_shifted[RES_W-1:0]};
    end

    assign acc_shifted = acc >>> OUT_SHIFT;
    assign operand     = (cnt_reg < TAP_IDX_W'(HIST)) ? rd_data : sample_reg;

    flp_delay u_delay (
        .clk       (clk),
        .push_en   (push_en),
        .push_data (push_data),
        .rd_idx    (cnt_reg[HIST_IDX_W-1:0]),
        .rd_data   (rd_data)
    );

    flp_mac u_mac (
        .clk     (clk),
        .ctrl    (ctrl),
        .operand (operand),
        .coef    (tap_at(cnt_reg)),
        .acc     (acc)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while the sequencer is busy");

    a_load_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (fill_reg == FILL_W'(HIST)))
        else $error("result produced before the delay line was full");

    a_last_tap_then_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && cnt_reg == TAP_IDX_W'(TAPS - 1)) |=> (state_reg == ST_ADD))
        else $error("sequencer skipped the final accumulate");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg <= TAP_IDX_W'(TAPS - 1)))
        else $error("tap counter out of range");

endmodule

[tb/sv/fir_window_checker.sv]
`timescale 1ns / 1ps

module fir_window_checker
    import flp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               mismatches,
    output int               waiting
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic [TIME_W-1:0]   stamp;
        logic [RES_W-1:0]    level;
    } fir_result_t;

    localparam longint COEFS [9] = '{
        -64'sd281468814, 64'sd106520334, 64'sd127255214,
         64'sd162830244, 64'sd205727178, 64'sd248615023,
         64'sd284705529, 64'sd308612275, 64'sd316959956
    };

    logic [SAMPLE_W-1:0] window [HIST];
    int                  filled;
    fir_result_t         filtered_due [$];

    function automatic longint coef_for(int i);
        int k;
        k = (i < TAPS - 1 - i) ? i : TAPS - 1 - i;
        if (k > $size(COEFS) - 1)
            k = $size(COEFS) - 1;
        return COEFS[k];
    endfunction

    function automatic logic [RES_W-1:0] weighted_sum(logic [SAMPLE_W-1:0] newest);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shifted;
        logic [SAMPLE_W-1:0]     v;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            v = (i < HIST) ? window[i] : newest;
            acc += longint'($signed(v)) * coef_for(i);
        end
        shifted = acc >>> OUT_SHIFT;
        return shifted[RES_W-1:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < 50)
            $display("mismatch in %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fir_result_t         got;
        fir_result_t         want;
        logic [SAMPLE_W-1:0] sample;
        if (!rst_n)
        begin
            filtered_due.delete();
            filled = 0;
            mismatches = 0;
            waiting <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (filtered_due.size() == 0)
                    report("result with nothing expected", 64'(got.level), '0);
                else
                begin
                    want = filtered_due.pop_front();
                    if (got.level !== want.level)
                        report("filtered_magnitude", 64'(got.level), 64'(want.level));
                    if (got.stamp !== want.stamp)
                        report("out_time", 64'(got.stamp), 64'(want.stamp));
                    if (got.raw !== want.raw)
                        report("out_raw_magnitude", 64'(got.raw), 64'(want.raw));
                end
            end
            if (s_tvalid && s_tready)
            begin
                sample = s_tdata[SAMPLE_W-1:0];
                if (filled < HIST)
                    filled++;
                else
                begin
                    want.level = weighted_sum(sample);
                    want.stamp = s_tdata[SAMPLE_W +: TIME_W];
                    want.raw   = s_tdata[SAMPLE_W + TIME_W +: SAMPLE_W];
                    filtered_due.push_back(want);
                end
                for (int j = 0; j < HIST - 1; j++)
                    window[j] = window[j + 1];
                window[HIST - 1] = sample;
            end
            waiting <= filtered_due.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb
    import flp_pkg::*;
();

    localparam int QUIET_LIMIT = 2000;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               mismatches;
    int               waiting;
    bit               gaps_on;

    fir_lowpass_17tap dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fir_window_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_sample(logic [31:0] mag, logic [31:0] stamp, logic [31:0] raw);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw, stamp, mag};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin
        int cyc;
        cyc = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc >= 3000 && cyc < 3400)
                m_tready <= 1'b0;
            else if (cyc >= 8000 && cyc < 16000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 38);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    initial
    begin
        int          mode;
        int          burst_left;
        int          pos;
        bit          flip;
        logic [31:0] mag;
        logic [31:0] stamp;
        logic [31:0] raw;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        gaps_on  = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The warm-up window is shaped so that the first result is the largest positive sum.
        send_sample(S_MIN, 32'h0, S_MAX);
        for (int i = 1; i < HIST; i++)
            send_sample(S_MAX, 32'(i), i[0] ? S_MIN : 32'h0);
        send_sample(S_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(S_MAX, 32'hFFFF_FFFE, S_MIN);
        send_sample(32'h0, 32'h0, 32'h0);
        send_sample(32'hFFFF_FFFF, 32'h8000_0000, S_MAX);
        send_sample(32'h1, 32'h7FFF_FFFF, 32'h1);
        send_sample(S_MIN, 32'h5555_5555, 32'hAAAA_AAAA);

        burst_left = 0;
        pos = 0;
        flip = 1'b0;
        mode = 0;
        stamp = 32'h0;
        for (int n = 0; n < 1900; n++)
        begin
            if (burst_left == 0)
            begin
                mode = $urandom_range(0, 5);
                burst_left = $urandom_range(17, 60);
                pos = 0;
                flip = $urandom_range(0, 1);
            end
            gaps_on = !(n >= 700 && n < 1000);
            case (mode)
                2: mag = S_MAX;
                3: mag = S_MIN;
                4: mag = 32'($urandom_range(0, 511)) - 32'd256;
                5: mag = ((pos % TAPS == 0) ^ flip) ? S_MIN : S_MAX;
                default: mag = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
                stamp = $urandom;
            else
                stamp = stamp + 32'($urandom_range(1, 40));
            raw = $urandom;
            send_sample(mag, stamp, raw);
            burst_left--;
            pos++;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[fir_lowpass_17tap.f]
rtl/flp_pkg.sv
rtl/flp_delay.sv
rtl/flp_mac.sv
rtl/fir_lowpass_17tap.sv
tb/sv/fir_window_checker.sv
tb/sv/tb.sv
